[sv/spc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package spc_pkg;

    localparam int SEG_DEPTH = 256;
    localparam int IDX_W     = $clog2(SEG_DEPTH);
    localparam int CNT_W     = $clog2(SEG_DEPTH + 1);
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int Q_ONE     = 4096;

    // reach flag bit positions
    localparam int F_BOTTOM = 0;
    localparam int F_TOP    = 1;
    localparam int F_LEFT   = 2;
    localparam int F_RIGHT  = 3;

    localparam int CFG_PASS_COUNT = 0;
    localparam int CFG_MIN_RISE   = 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ye;
    } seg_t;

    typedef struct packed {
        logic             seg_we;
        logic             flag_we;
        logic             load;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] rd_addr;
        logic             latch_i;
        logic             diff_en;
        logic             mul_en;
        logic             acc_clr;
        logic             acc_en;
    } spc_cmd_t;

endpackage
`default_nettype wire

[sv/spc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module spc_datapath (
    input  wire logic                         clk,
    input  wire spc_pkg::spc_cmd_t            cmd,
    input  wire logic [12:0]                  min_rise,
    input  wire logic signed [15:0]           x_start,
    input  wire logic signed [15:0]           y_start,
    input  wire logic signed [15:0]           x_end,
    input  wire logic signed [15:0]           y_end,
    input  wire logic                         seed_bottom,
    input  wire logic                         seed_top,
    output logic                              spans_vertical,
    output logic                              spans_horizontal,
    output logic [8:0]                        vertical_count,
    output logic signed [9:0]                 horizontal_excess
);
    import spc_pkg::*;

    seg_t       seg_mem [SEG_DEPTH];
    logic [3:0] flag_mem [SEG_DEPTH];

    seg_t       seg_rd_reg;
    logic [3:0] flag_rd_reg;
    seg_t       seg_i_reg;
    logic [3:0] fi_reg;
    logic [3:0] fj_reg;
    logic       steep_i_reg;
    logic       steep_j_reg;

    logic signed [DIFF_W-1:0] dxi_reg, dyi_reg, dxj_reg, dyj_reg;
    logic signed [DIFF_W-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [DIFF_W-1:0] c1_reg, d1_reg, c2_reg, d2_reg;
    logic signed [PROD_W-1:0] p_reg [8];

    logic [CNT_W-1:0] vc_reg;
    logic [CNT_W-1:0] hc_reg;

    logic [3:0] load_flags;
    logic [3:0] upd_flags;
    logic [3:0] flag_wdata;
    logic signed [SUM_W-1:0] s1, s2, s3, s4;
    logic straddle_ij, straddle_ji, conn;

    function automatic logic steep_of(seg_t s, logic [12:0] mr);
        logic signed [DIFF_W:0] rise;
        rise = (DIFF_W+1)'(s.ye) - (DIFF_W+1)'(s.ys);
        return rise > $signed({{(DIFF_W-13){1'b0}}, mr});
    endfunction

    always_comb
    begin
        load_flags[F_BOTTOM] = seed_bottom;
        load_flags[F_TOP]    = seed_top;
        load_flags[F_LEFT]   = (x_start < 0) || (x_end < 0);
        load_flags[F_RIGHT]  = (x_start > COORD_W'(Q_ONE)) || (x_end > COORD_W'(Q_ONE));
    end

    always_comb
    begin
        s1 = SUM_W'(p_reg[0]) + SUM_W'(p_reg[1]);
        s2 = SUM_W'(p_reg[2]) + SUM_W'(p_reg[3]);
        s3 = SUM_W'(p_reg[4]) + SUM_W'(p_reg[5]);
        s4 = SUM_W'(p_reg[6]) + SUM_W'(p_reg[7]);
        straddle_ij = !((s1 > 0 && s2 > 0) || (s1 < 0 && s2 < 0));
        straddle_ji = !((s3 > 0 && s4 > 0) || (s3 < 0 && s4 < 0));
        conn = straddle_ij && straddle_ji;
        upd_flags = fj_reg;
        if (conn && steep_i_reg && steep_j_reg && fi_reg[F_BOTTOM])
            upd_flags[F_BOTTOM] = 1'b1;
        if (conn && steep_i_reg && steep_j_reg && fi_reg[F_TOP])
            upd_flags[F_TOP] = 1'b1;
        if (conn && fi_reg[F_LEFT])
            upd_flags[F_LEFT] = 1'b1;
        if (conn && fi_reg[F_RIGHT])
            upd_flags[F_RIGHT] = 1'b1;
        flag_wdata = cmd.load ? load_flags : upd_flags;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seg_we)
            seg_mem[cmd.wr_addr] <= '{xs: x_start, ys: y_start, xe: x_end, ye: y_end};
        if (cmd.flag_we)
            flag_mem[cmd.wr_addr] <= flag_wdata;
        seg_rd_reg  <= seg_mem[cmd.rd_addr];
        flag_rd_reg <= flag_mem[cmd.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_i)
        begin
            seg_i_reg <= seg_rd_reg;
            fi_reg    <= flag_rd_reg;
        end
        if (cmd.diff_en)
        begin
            fj_reg      <= flag_rd_reg;
            steep_i_reg <= steep_of(seg_i_reg, min_rise);
            steep_j_reg <= steep_of(seg_rd_reg, min_rise);
            dxi_reg <= DIFF_W'(seg_i_reg.xs) - DIFF_W'(seg_i_reg.xe);
            dyi_reg <= DIFF_W'(seg_i_reg.ys) - DIFF_W'(seg_i_reg.ye);
            dxj_reg <= DIFF_W'(seg_rd_reg.xs) - DIFF_W'(seg_rd_reg.xe);
            dyj_reg <= DIFF_W'(seg_rd_reg.ys) - DIFF_W'(seg_rd_reg.ye);
            a1_reg  <= DIFF_W'(seg_rd_reg.ys) - DIFF_W'(seg_i_reg.ys);
            b1_reg  <= DIFF_W'(seg_i_reg.xs) - DIFF_W'(seg_rd_reg.xs);
            a2_reg  <= DIFF_W'(seg_rd_reg.ye) - DIFF_W'(seg_i_reg.ys);
            b2_reg  <= DIFF_W'(seg_i_reg.xs) - DIFF_W'(seg_rd_reg.xe);
            c1_reg  <= DIFF_W'(seg_i_reg.ys) - DIFF_W'(seg_rd_reg.ys);
            d1_reg  <= DIFF_W'(seg_rd_reg.xs) - DIFF_W'(seg_i_reg.xs);
            c2_reg  <= DIFF_W'(seg_i_reg.ye) - DIFF_W'(seg_rd_reg.ys);
            d2_reg  <= DIFF_W'(seg_rd_reg.xs) - DIFF_W'(seg_i_reg.xe);
        end
        if (cmd.mul_en)
        begin
            p_reg[0] <= PROD_W'(dxi_reg) * PROD_W'(a1_reg);
            p_reg[1] <= PROD_W'(dyi_reg) * PROD_W'(b1_reg);
            p_reg[2] <= PROD_W'(dxi_reg) * PROD_W'(a2_reg);
            p_reg[3] <= PROD_W'(dyi_reg) * PROD_W'(b2_reg);
            p_reg[4] <= PROD_W'(dxj_reg) * PROD_W'(c1_reg);
            p_reg[5] <= PROD_W'(dyj_reg) * PROD_W'(d1_reg);
            p_reg[6] <= PROD_W'(dxj_reg) * PROD_W'(c2_reg);
            p_reg[7] <= PROD_W'(dyj_reg) * PROD_W'(d2_reg);
        end
        if (cmd.acc_clr)
        begin
            vc_reg <= '0;
            hc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            if (flag_rd_reg[F_BOTTOM] && flag_rd_reg[F_TOP])
                vc_reg <= vc_reg + CNT_W'(1);
            if (flag_rd_reg[F_LEFT] && flag_rd_reg[F_RIGHT])
                hc_reg <= hc_reg + CNT_W'(1);
        end
    end

    assign spans_vertical    = (vc_reg != '0);
    assign spans_horizontal  = (hc_reg != '0);
    assign vertical_count    = 9'(vc_reg);
    assign horizontal_excess = 10'(hc_reg) - 10'(vc_reg);

endmodule
`default_nettype wire

[sv/spc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module spc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 last_segment,
    input  wire logic [7:0]           pass_count,
    output logic                      busy,
    output logic                      done,
    output spc_pkg::spc_cmd_t         cmd
);
    import spc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_I, S_LD_I, S_RD_J, S_DIFF, S_MUL, S_UPD, S_CNT_RD, S_CNT_ACC, S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [7:0]       pass_reg, pass_next;
    logic             accept, store_ok;
    logic [CNT_W-1:0] last_idx;

    assign accept   = start && (state_reg == S_IDLE);
    assign store_ok = (count_reg < CNT_W'(SEG_DEPTH));
    assign last_idx = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        cmd.rd_addr = i_reg[IDX_W-1:0];
        cmd.wr_addr = j_reg[IDX_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.wr_addr = count_reg[IDX_W-1:0];
                cmd.load    = 1'b1;
                cmd.seg_we  = accept && store_ok;
                cmd.flag_we = accept && store_ok;
                if (accept && store_ok)
                    count_next = count_reg + CNT_W'(1);
                if (accept && last_segment)
                begin
                    i_next    = '0;
                    pass_next = '0;
                    if (pass_count == '0)
                    begin
                        cmd.acc_clr = 1'b1;
                        state_next  = S_CNT_RD;
                    end
                    else
                        state_next = S_RD_I;
                end
            end
            S_RD_I:
                state_next = S_LD_I;
            S_LD_I:
            begin
                cmd.latch_i = 1'b1;
                j_next      = '0;
                state_next  = S_RD_J;
            end
            S_RD_J:
            begin
                cmd.rd_addr = j_reg[IDX_W-1:0];
                state_next  = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.flag_we = 1'b1;
                if (j_reg != last_idx)
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_RD_J;
                end
                else if (i_reg != last_idx)
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_RD_I;
                end
                else if (pass_reg != pass_count - 8'd1)
                begin
                    pass_next  = pass_reg + 8'd1;
                    i_next     = '0;
                    state_next = S_RD_I;
                end
                else
                begin
                    i_next      = '0;
                    cmd.acc_clr = 1'b1;
                    state_next  = S_CNT_RD;
                end
            end
            S_CNT_RD:
                state_next = S_CNT_ACC;
            S_CNT_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (i_reg != last_idx)
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_CNT_RD;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                count_next = '0;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pass_reg  <= pass_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule
`default_nettype wire

[sv/segment_percolation_spanning_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Stick percolation spanning check.
// Segments are loaded with start while busy is low, one per cycle. Each
// load stores the endpoints and seeds the reach flags; loads beyond 256
// segments are dropped. A load with last_segment set raises busy and runs
// pass_count propagation passes over the n stored segments, then counts
// the flags and presents one result on done for exactly one cycle.
// The single read port of the segment memory sets the pace from the last
// load to done: each segment pair takes read, difference, multiply and
// update steps in turn.
// The receiver cannot stall; the result fields hold until the next batch.
// Configuration (cfg_we, cfg_index, cfg_data) is written while busy is low:
// index 0 is pass_count, index 1 is min_rise.
// Reset returns to idle with an empty store and the register defaults.
module segment_percolation_spanning_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] x_start,
    input  wire logic signed [15:0] y_start,
    input  wire logic signed [15:0] x_end,
    input  wire logic signed [15:0] y_end,
    input  wire logic               seed_bottom,
    input  wire logic               seed_top,
    input  wire logic               last_segment,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [12:0]        cfg_data,
    output logic                    done,
    output logic                    spans_vertical,
    output logic                    spans_horizontal,
    output logic [8:0]              vertical_count,
    output logic signed [9:0]       horizontal_excess
);
    import spc_pkg::*;

    logic [7:0]  pass_count_reg;
    logic [12:0] min_rise_reg;
    spc_cmd_t    cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_count_reg <= 8'd100;
            min_rise_reg   <= 13'd655;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(CFG_PASS_COUNT))
                pass_count_reg <= cfg_data[7:0];
            else
                min_rise_reg <= cfg_data;
        end
    end

    spc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_segment (last_segment),
        .pass_count   (pass_count_reg),
        .busy         (busy),
        .done         (done),
        .cmd          (cmd)
    );

    spc_datapath u_datapath (
        .clk               (clk),
        .cmd               (cmd),
        .min_rise          (min_rise_reg),
        .x_start           (x_start),
        .y_start           (y_start),
        .x_end             (x_end),
        .y_end             (y_end),
        .seed_bottom       (seed_bottom),
        .seed_top          (seed_top),
        .spans_vertical    (spans_vertical),
        .spans_horizontal  (spans_horizontal),
        .vertical_count    (vertical_count),
        .horizontal_excess (horizontal_excess)
    );

endmodule
`default_nettype wire

[sim/segment_percolation_spanning_top_test.sv]
`timescale 1ns / 1ps
module segment_percolation_spanning_top_test;
    import spc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000000;

    typedef struct packed {
        logic              sv;
        logic              sh;
        logic [8:0]        vc;
        logic signed [9:0] ex;
    } span_result_t;

    class spanning_scoreboard;
        longint      seg_xs[SEG_DEPTH];
        longint      seg_ys[SEG_DEPTH];
        longint      seg_xe[SEG_DEPTH];
        longint      seg_ye[SEG_DEPTH];
        bit [3:0]    reach[SEG_DEPTH];
        int unsigned stored;
        int unsigned passes;
        int unsigned rise_min;
        span_result_t pending[$];
        int          errors;
        int          results;
        int          segments;

        function new();
            stored = 0;
            passes = 100;
            rise_min = 655;
            errors = 0;
            results = 0;
            segments = 0;
        endfunction

        function void set_reg(int idx, int unsigned value);
            if (idx == CFG_PASS_COUNT)
                passes = value & 8'hff;
            else if (idx == CFG_MIN_RISE)
                rise_min = value & 13'h1fff;
        endfunction

        // products of 17-bit differences fit easily in 64 bits
        function int sign_sum(longint a, longint b, longint c, longint d);
            longint s;
            s = a * b + c * d;
            return (s > 0) ? 1 : ((s < 0) ? -1 : 0);
        endfunction

        function bit straddles(int p, int q);
            longint dx, dy;
            int t1, t2;
            dx = seg_xs[p] - seg_xe[p];
            dy = seg_ys[p] - seg_ye[p];
            t1 = sign_sum(dx, seg_ys[q] - seg_ys[p], dy, seg_xs[p] - seg_xs[q]);
            t2 = sign_sum(dx, seg_ye[q] - seg_ys[p], dy, seg_xs[p] - seg_xe[q]);
            return !(t1 * t2 > 0);
        endfunction

        function bit steep(int i);
            return (seg_ye[i] - seg_ys[i]) > longint'(rise_min);
        endfunction

        function void spread(int i, int b, bit need_steep);
            for (int j = 0; j < stored; j++) begin
                if (need_steep && !steep(j))
                    continue;
                if (!reach[j][b] && straddles(i, j) && straddles(j, i))
                    reach[j][b] = 1'b1;
            end
        endfunction

        function void note_segment(logic signed [15:0] xs, logic signed [15:0] ys,
                                   logic signed [15:0] xe, logic signed [15:0] ye,
                                   logic sb, logic st, logic last);
            int unsigned vc, hc;
            bit sv, sh;
            span_result_t r;
            segments++;
            if (stored < SEG_DEPTH) begin
                seg_xs[stored] = xs;
                seg_ys[stored] = ys;
                seg_xe[stored] = xe;
                seg_ye[stored] = ye;
                reach[stored] = '0;
                reach[stored][F_BOTTOM] = sb;
                reach[stored][F_TOP] = st;
                reach[stored][F_LEFT] = (xs < 0) || (xe < 0);
                reach[stored][F_RIGHT] = (xs > Q_ONE) || (xe > Q_ONE);
                stored++;
            end
            if (!last)
                return;
            // in-place update: flags set earlier in a pass are seen later in it
            for (int k = 0; k < passes; k++)
                for (int i = 0; i < stored; i++) begin
                    if (steep(i)) begin
                        if (reach[i][F_BOTTOM]) spread(i, F_BOTTOM, 1'b1);
                        if (reach[i][F_TOP]) spread(i, F_TOP, 1'b1);
                    end
                    if (reach[i][F_LEFT]) spread(i, F_LEFT, 1'b0);
                    if (reach[i][F_RIGHT]) spread(i, F_RIGHT, 1'b0);
                end
            vc = 0;
            hc = 0;
            sv = 0;
            sh = 0;
            for (int i = 0; i < stored; i++) begin
                if (reach[i][F_BOTTOM] && reach[i][F_TOP]) begin
                    sv = 1;
                    vc++;
                end
                if (reach[i][F_LEFT] && reach[i][F_RIGHT]) begin
                    sh = 1;
                    hc++;
                end
            end
            r.sv = sv;
            r.sh = sh;
            r.vc = vc[8:0];
            r.ex = 10'(hc - vc);
            pending.push_back(r);
            stored = 0;
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(span_result_t got);
            span_result_t want;
            results++;
            if (pending.size() == 0) begin
                report("result with no transaction pending");
                return;
            end
            want = pending.pop_front();
            if (got.sv !== want.sv)
                report($sformatf("spans_vertical %b, want %b", got.sv, want.sv));
            if (got.sh !== want.sh)
                report($sformatf("spans_horizontal %b, want %b", got.sh, want.sh));
            if (got.vc !== want.vc)
                report($sformatf("vertical_count %0d, want %0d", got.vc, want.vc));
            if (got.ex !== want.ex)
                report($sformatf("horizontal_excess %0d, want %0d", got.ex, want.ex));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] x_start = '0;
    logic signed [15:0] y_start = '0;
    logic signed [15:0] x_end = '0;
    logic signed [15:0] y_end = '0;
    logic               seed_bottom = 1'b0;
    logic               seed_top = 1'b0;
    logic               last_segment = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [12:0]        cfg_data = '0;
    logic               done;
    logic               spans_vertical;
    logic               spans_horizontal;
    logic [8:0]         vertical_count;
    logic signed [9:0]  horizontal_excess;

    spanning_scoreboard sb = new();
    int idle_pct = 0;
    int batches = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    segment_percolation_spanning_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
        .seed_bottom(seed_bottom), .seed_top(seed_top), .last_segment(last_segment),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .spans_vertical(spans_vertical),
        .spans_horizontal(spans_horizontal), .vertical_count(vertical_count),
        .horizontal_excess(horizontal_excess)
    );

    always @(posedge clk) begin
        if (rst_n && done)
            sb.check_result({spans_vertical, spans_horizontal, vertical_count,
                             horizontal_excess});
        if (rst_n && (done || (start && !busy)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task write_reg(int idx, int unsigned value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx[0];
        cfg_data = value[12:0];
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, value);
    endtask

    task send_segment(logic signed [15:0] xs, logic signed [15:0] ys,
                      logic signed [15:0] xe, logic signed [15:0] ye,
                      logic sbot, logic stop, logic last);
        // already at a falling edge when the previous transaction just ended
        if (clk)
            @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        x_start = xs;
        y_start = ys;
        x_end = xe;
        y_end = ye;
        seed_bottom = sbot;
        seed_top = stop;
        last_segment = last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_segment(xs, ys, xe, ye, sbot, stop, last);
        if (last)
            batches++;
        @(negedge clk);
        start = 1'b0;
    endtask

    // wait for every pending result, then let the block settle
    task drain;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function logic signed [15:0] near_coord();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(7000)) - 1500);
    endfunction

    task random_segment(logic last);
        logic signed [15:0] xs, ys, xe, ye;
        xs = near_coord();
        ys = near_coord();
        xe = near_coord();
        ye = near_coord();
        // mostly rising sticks so bottom/top reach can spread
        if ($urandom_range(3) != 0 && ye < ys) begin
            ye = ys;
            ys = 16'(ye - $urandom_range(3000));
        end
        send_segment(xs, ys, xe, ye, $urandom_range(3) == 0, $urandom_range(3) == 0, last);
    endtask

    task random_phase(int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            write_reg(CFG_PASS_COUNT, $urandom_range(1, 6));
            write_reg(CFG_MIN_RISE, $urandom_range(4096));
            repeat ($urandom_range(1, 4)) begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    random_segment(i == n - 1);
                sent += n;
            end
            drain();
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers; field extremes, seeds, touching sticks
        send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0, 1'b0);
        send_segment(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, 1'b1, 1'b0);
        send_segment(-16'sd10, 0, 16'sd5000, 16'sd4000, 1'b1, 1'b1, 1'b0);
        send_segment(0, 16'sd2000, 16'sd4096, 16'sd2000, 1'b0, 1'b0, 1'b1);
        drain();
        // touching at an endpoint; seeded but too flat to spread
        write_reg(CFG_PASS_COUNT, 255);
        write_reg(CFG_MIN_RISE, 4096);
        send_segment(0, 0, 16'sd2000, 16'sd5000, 1'b1, 1'b0, 1'b0);
        send_segment(16'sd2000, 16'sd5000, 16'sd4097, 16'sd9500, 1'b0, 1'b1, 1'b0);
        send_segment(16'sd4097, 16'sd9500, 16'sd4097, 16'sd9600, 1'b1, 1'b1, 1'b1);
        drain();
        // zero passes and no rise threshold; collinear overlap
        write_reg(CFG_PASS_COUNT, 0);
        write_reg(CFG_MIN_RISE, 0);
        send_segment(-16'sd1, 0, 16'sd100, 16'sd100, 1'b1, 1'b0, 1'b0);
        send_segment(16'sd50, 16'sd50, 16'sd5000, 16'sd5000, 1'b0, 1'b1, 1'b1);
        drain();
        write_reg(CFG_PASS_COUNT, 1);
        send_segment(-16'sd1, 0, 16'sd100, 16'sd100, 1'b1, 1'b0, 1'b0);
        send_segment(16'sd50, 16'sd50, 16'sd5000, 16'sd5000, 1'b0, 1'b1, 1'b0);
        send_segment(16'sd100, 0, 0, 16'sd100, 1'b1, 1'b1, 1'b1);
        drain();
        // full store: the last transaction is dropped but still ends the batch
        for (int i = 0; i <= SEG_DEPTH; i++)
            random_segment(i == SEG_DEPTH);
        drain();

        idle_pct = 22;
        random_phase(320);
        idle_pct = 84;
        random_phase(320);
        idle_pct = 0;
        random_phase(320);

        drain();
        $display("covered %0d segments in %0d batches, %0d results checked",
                 sb.segments, batches, sb.results);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[segment_percolation_spanning_top.f]
sv/spc_pkg.sv
sv/spc_datapath.sv
sv/spc_ctrl.sv
sv/segment_percolation_spanning_top.sv
sim/segment_percolation_spanning_top_test.sv
